// File: design/kce_pkg.sv
// Package for the keyframe curve evaluator: sizes, the sequencer state
// type and the Q16.16 saturation helper. No dependencies.
package kce_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int NUM_CH       = 3;
  localparam int FRAC_W       = 16;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 7;
  localparam int KIDX_W       = 6;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [1:0] REG_COUNT_X = 2'd0;
  localparam logic [1:0] REG_COUNT_Y = 2'd1;
  localparam logic [1:0] REG_COUNT_Z = 2'd2;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_FIRST = 9'b000000100,
    S_RD    = 9'b000001000,
    S_WALK  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_ADV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [34:0] v);
    logic signed [34:0] hi;
    logic signed [34:0] lo;
    hi = 35'sh0_7FFF_FFFF;
    lo = -35'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[VAL_W-1:0];
    end
  endfunction

endpackage

// File: design/keyframe_curve_evaluator_top.sv
// Channel   | dir | handshake           | payload
// in_       | in  | in_tvalid/in_tready | tuser: command; tdata: see port
// out_      | out | out_tvalid/tready   | tdata: value_x, value_y, value_z
// cfg_      | in  | cfg_we              | cfg_index, cfg_wdata (key counts)
// A query walks each channel's keys in the key RAMs, a RAM read then a
// compare for each key, and for an interpolation runs the divider, then the
// multiply and sum, over three channels. Reset is synchronous; the key RAMs
// are not cleared. A finished result waits in the output register while the
// next item is taken; the sequencer stalls only if that register is full.
module keyframe_curve_evaluator_top
  import kce_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,   // command
  input  logic [103:0] in_tdata,   // channel, key_index, key_time, key_value, query_time
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // value_x, value_y, value_z
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_wdata
);

  localparam int DEPTH  = NUM_CH * MAX_KEYS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_KEYS + 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r [NUM_CH];
  logic [1:0]       ch_r, ch_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, n_r, n_nxt, n_cur;
  logic signed [VAL_W-1:0] t_r, t_nxt;
  logic signed [VAL_W-1:0] pt_r, pt_nxt, pv_r, pv_nxt, cv_r, cv_nxt;
  logic signed [VAL_W-1:0] res_r [NUM_CH];
  logic signed [VAL_W-1:0] res_val;
  logic             res_we;
  logic signed [49:0] prod_r;
  logic [95:0]      out_r;
  logic             out_valid_r;

  logic [1:0]        f_ch;
  logic [KIDX_W-1:0] f_idx;
  logic [VAL_W-1:0]  f_ktime, f_kval, f_qtime;
  logic              wr_go, acc;
  logic [ADDR_W-1:0] wr_addr, rd_addr, ram_addr;
  logic [VAL_W-1:0]  ram_t, ram_v;
  logic signed [VAL_W-1:0] kt, kv;

  logic              div_start, div_done;
  logic [VAL_W-1:0]  div_d, div_s;
  logic [FRAC_W-1:0] frac;
  logic signed [50:0] sum;

  assign f_ch    = in_tdata[1:0];
  assign f_idx   = in_tdata[7:2];
  assign f_ktime = in_tdata[39:8];
  assign f_kval  = in_tdata[71:40];
  assign f_qtime = in_tdata[103:72];

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign wr_go     = acc && (in_tuser == CMD_WRITE) && (32'(f_ch) < 32'(NUM_CH))
                     && (32'(f_idx) < 32'(MAX_KEYS));
  assign wr_addr   = ADDR_W'(32'(f_ch) * 32'(MAX_KEYS) + 32'(f_idx));
  assign rd_addr   = ADDR_W'(32'(ch_r) * 32'(MAX_KEYS) + 32'(i_r));
  assign ram_addr  = wr_go ? wr_addr : rd_addr;

  kce_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_time_ram (
    .clk(clk), .we(wr_go), .addr(ram_addr), .wdata(f_ktime), .rdata(ram_t)
  );
  kce_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_value_ram (
    .clk(clk), .we(wr_go), .addr(ram_addr), .wdata(f_kval), .rdata(ram_v)
  );

  assign kt = $signed(ram_t);
  assign kv = $signed(ram_v);

  kce_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_d),
    .divisor(div_s), .done(div_done), .quot(frac)
  );

  assign div_d = VAL_W'(t_r - pt_r);
  assign div_s = VAL_W'(kt - pt_r);

  always_comb begin
    logic [CNT_W-1:0] c;
    c = count_r[ch_r];
    if (32'(c) > 32'(MAX_KEYS)) begin
      n_cur = IDX_W'(MAX_KEYS);
    end else begin
      n_cur = IDX_W'(c);
    end
  end

  assign sum = (51'(pv_r) <<< FRAC_W) + 51'(prod_r) + 51'sd32768;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    t_nxt     = t_r;
    pt_nxt    = pt_r;
    pv_nxt    = pv_r;
    cv_nxt    = cv_r;
    res_we    = 1'b0;
    res_val   = '0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc && (in_tuser == CMD_EVAL)) begin
          t_nxt     = $signed(f_qtime);
          ch_nxt    = '0;
          i_nxt     = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        n_nxt = n_cur;
        if (n_cur == '0) begin
          res_we    = 1'b1;
          state_nxt = S_ADV;
        end else begin
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        pt_nxt = kt;
        pv_nxt = kv;
        if (t_r < kt || n_r == IDX_W'(1)) begin
          res_we    = 1'b1;
          res_val   = kv;
          state_nxt = S_ADV;
        end else begin
          i_nxt     = IDX_W'(1);
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (t_r == kt) begin
          res_we    = 1'b1;
          res_val   = kv;
          state_nxt = S_ADV;
        end else if (t_r < kt) begin
          div_start = 1'b1;
          cv_nxt    = kv;
          state_nxt = S_DIV;
        end else if (i_r == n_r - IDX_W'(1)) begin
          res_we    = 1'b1;
          res_val   = kv;
          state_nxt = S_ADV;
        end else begin
          pt_nxt    = kt;
          pv_nxt    = kv;
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_RD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        res_we    = 1'b1;
        res_val   = sat32(sum[50:16]);
        state_nxt = S_ADV;
      end
      S_ADV: begin
        i_nxt = '0;
        if (ch_r == 2'(NUM_CH - 1)) begin
          state_nxt = S_OUT;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_START;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_CH; k++) begin
        count_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_COUNT_X: count_r[0] <= cfg_wdata;
          REG_COUNT_Y: count_r[1] <= cfg_wdata;
          REG_COUNT_Z: count_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    i_r    <= i_nxt;
    n_r    <= n_nxt;
    t_r    <= t_nxt;
    pt_r   <= pt_nxt;
    pv_r   <= pv_nxt;
    cv_r   <= cv_nxt;
    prod_r <= (33'(cv_r) - 33'(pv_r)) * $signed({1'b0, frac});
    if (res_we) begin
      res_r[ch_r] <= res_val;
    end
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_r <= {res_r[2], res_r[1], res_r[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

// File: design/kce_ram.sv
// Generic single-port synchronous RAM, registered read, one write port.
// No dependencies.
module kce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/kce_div.sv
// Restoring divider for the Q0.16 interpolation fraction, one bit a cycle.
// Depends on kce_pkg.
module kce_div
  import kce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VAL_W-1:0]  dividend,
  input  logic [VAL_W-1:0]  divisor,
  output logic              done,
  output logic [FRAC_W-1:0] quot
);

  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [VAL_W-1:0]  den_r;
  logic [FRAC_W-1:0] q_r, q_nxt;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic [VAL_W:0]    shifted;

  always_comb begin
    shifted = {rem_r, 1'b0};
    if (shifted >= {1'b0, den_r}) begin
      rem_nxt = VAL_W'(shifted - {1'b0, den_r});
      q_nxt   = {q_r[FRAC_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[VAL_W-1:0];
      q_nxt   = {q_r[FRAC_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(FRAC_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      den_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = busy_r && (cnt_r == 5'(FRAC_W - 1));
  assign quot = q_nxt;

endmodule

// File: tb/sv/testbench.sv
// Self-checking bench for keyframe_curve_evaluator_top: key writes and queries go
// in on the in_ stream, and each query's three channel values are checked
// against a local interpolation model. Depends on kce_pkg and the top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kce_pkg::*;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        cmd;
    logic [1:0]  ch;
    logic [5:0]  idx;
    logic [31:0] ktime;
    logic [31:0] kval;
    logic [31:0] qtime;
    logic [6:0]  cx, cy, cz;
    bit          typed;
    logic [31:0] ex, ey, ez;
  } row_t;

  typedef struct {
    logic [31:0] vx, vy, vz;
  } triple_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic         in_tuser;
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [6:0]   cfg_wdata;

  int          knot_time [3][64];
  int          knot_val  [3][64];
  bit          knot_set  [3][64];
  int          key_count [3];
  triple_t     pending_vals[$];
  int          errors;
  int          tx_idle_pct;
  int          rx_idle_pct;
  row_t        dir_tab[$];

  keyframe_curve_evaluator_top i_dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  function automatic logic [31:0] channel_value(int ch, int cnt, logic [31:0] tq);
    int     n;
    longint tt, t0, t1, v0, v1, f, acc;
    n = (cnt > 64) ? 64 : cnt;
    tt = longint'($signed(tq));
    if (n == 0) return 32'd0;
    if (tt < knot_time[ch][0]) return knot_val[ch][0];
    for (int i = 1; i < n; i++) begin
      t1 = knot_time[ch][i];
      if (tt == t1) return knot_val[ch][i];
      if (tt < t1) begin
        t0 = knot_time[ch][i-1];
        v0 = knot_val[ch][i-1];
        v1 = knot_val[ch][i];
        f = ((tt - t0) <<< 16) / (t1 - t0);
        if (f > 65535) f = 65535;
        acc = (v0 * (65536 - f) + v1 * f + 32768) >>> 16;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc[31:0];
      end
    end
    return knot_val[ch][n-1];
  endfunction

  function automatic int written_prefix(int ch);
    int p;
    p = 0;
    while (p < 64 && knot_set[ch][p]) p++;
    return p;
  endfunction

  always @(posedge clk) begin
    triple_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_vals.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        e = pending_vals.pop_front();
        if (out_tdata[31:0] !== e.vx) begin
          $display("%0t: value_x exp %h got %h", $time, e.vx, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== e.vy) begin
          $display("%0t: value_y exp %h got %h", $time, e.vy, out_tdata[63:32]);
          errors++;
        end
        if (out_tdata[95:64] !== e.vz) begin
          $display("%0t: value_z exp %h got %h", $time, e.vz, out_tdata[95:64]);
          errors++;
        end
      end
    end
  end

  // drive one item, wait for it to be taken, then update the model
  task automatic send_item(logic cmd, logic [1:0] ch, logic [5:0] idx, logic [31:0] kt,
                           logic [31:0] kv, logic [31:0] qt, bit typed = 0,
                           triple_t tv = '{0, 0, 0});
    triple_t e;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {qt, kv, kt, idx, ch};
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_WRITE) begin
      if (ch < 3) begin
        knot_time[ch][idx] = kt;
        knot_val[ch][idx]  = kv;
        knot_set[ch][idx]  = 1'b1;
      end
    end else begin
      e.vx = channel_value(0, key_count[0], qt);
      e.vy = channel_value(1, key_count[1], qt);
      e.vz = channel_value(2, key_count[2], qt);
      pending_vals.insert(pending_vals.size(), typed ? tv : e);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_vals.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_counts(logic [6:0] cx, logic [6:0] cy, logic [6:0] cz);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_COUNT_X;
    cfg_wdata <= cx;
    @(posedge clk);
    cfg_index <= REG_COUNT_Y;
    cfg_wdata <= cy;
    @(posedge clk);
    cfg_index <= REG_COUNT_Z;
    cfg_wdata <= cz;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_count[0] = cx;
    key_count[1] = cy;
    key_count[2] = cz;
  endtask

  // load keys 0..n-1 of one channel in ascending time order
  task automatic load_table(int ch, int n);
    int          tq[$];
    int          base, step;
    int          vmode;
    logic [31:0] v;
    tq = {};
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < n; i++) tq.insert(i, int'($urandom));
      tq.sort();
    end else begin
      base = int'($urandom_range(0, 32'h40000)) - 32'sh20000;
      step = $urandom_range(1, 32'h30000);
      for (int i = 0; i < n; i++) tq.insert(i, base + i * step);
    end
    vmode = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      case (vmode)
        0: v = $urandom;
        1: v = $urandom_range(0, 32'h80000) - 32'h40000;
        default: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
      send_item(CMD_WRITE, ch[1:0], i[5:0], tq[i], v, $urandom);
    end
  endtask

  function automatic logic [31:0] pick_query();
    int ch, p, i, r;
    ch = $urandom_range(0, 2);
    p = written_prefix(ch);
    r = $urandom_range(0, 9);
    if (p == 0 || r == 7) return $urandom;
    i = $urandom_range(0, p - 1);
    if (r <= 3) return knot_time[ch][i];
    if (r <= 6) return knot_time[ch][i] + $urandom_range(0, 32'h20000) - 32'h10000;
    if (r == 8) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (i + 1 < p) return int'((longint'(knot_time[ch][i]) + knot_time[ch][i+1]) >>> 1);
    return knot_time[ch][i] + 1;
  endfunction

  task automatic pick_count(int ch, output logic [6:0] c);
    int p;
    p = written_prefix(ch);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: c = 7'(p);
      6, 7: c = 7'($urandom_range(0, p));
      8: c = (p == 64) ? 7'd127 : 7'd0;
      default: c = (p == 64) ? 7'($urandom_range(64, 127)) : 7'(p);
    endcase
  endtask

  initial begin
    triple_t     tv;
    logic [6:0]  c [3];
    int          items;
    errors = 0;
    tx_idle_pct = 35;
    rx_idle_pct = 62;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_WRITE;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_COUNT_X;
    cfg_wdata <= '0;
    for (int ch = 0; ch < 3; ch++) begin
      key_count[ch] = 0;
      for (int i = 0; i < 64; i++) knot_set[ch][i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty tables, ignored channel, extremes, unsorted keys
    dir_tab = '{
      '{ROW_ITEM, CMD_EVAL, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 1, 0, 0, 0},
      '{ROW_ITEM, CMD_EVAL, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 1, 0, 0, 0},
      '{ROW_ITEM, CMD_WRITE, 3, 6'h3F, 32'h1234, 32'h5678, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_WRITE, 0, 0, 32'hFFFF_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_WRITE, 0, 1, 32'h0001_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_WRITE, 1, 0, 32'h8000_0000, 32'h0001_2345, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_WRITE, 1, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFB, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_WRITE, 2, 0, 32'h0001_0000, 32'd100, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_WRITE, 2, 1, 32'h0000_0000, 32'd200, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_WRITE, 2, 2, 32'h0002_0000, 32'd300, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, 0, 0, 0, 0, 0, 0, 2, 2, 3, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_EVAL, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_EVAL, 0, 0, 0, 0, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_EVAL, 0, 0, 0, 0, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_EVAL, 0, 0, 0, 0, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_EVAL, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_EVAL, 0, 0, 0, 0, 32'h0001_8000, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_EVAL, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_CFG, 0, 0, 0, 0, 0, 0, 1, 0, 2, 0, 0, 0, 0},
      '{ROW_ITEM, CMD_EVAL, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 1,
        32'h7FFF_FFFF, 0, 32'd200},
      '{ROW_ITEM, CMD_EVAL, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0}
    };
    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        set_counts(dir_tab[k].cx, dir_tab[k].cy, dir_tab[k].cz);
      end else begin
        tv = '{dir_tab[k].ex, dir_tab[k].ey, dir_tab[k].ez};
        send_item(dir_tab[k].cmd, dir_tab[k].ch, dir_tab[k].idx, dir_tab[k].ktime,
                  dir_tab[k].kval, dir_tab[k].qtime, dir_tab[k].typed, tv);
      end
    end

    // random rounds: load sorted tables, set counts, query, with some noise writes
    items = 0;
    while (items < 800) begin
      if (items >= 533) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (items >= 267) begin
        tx_idle_pct = 62;
        rx_idle_pct = 35;
      end
      for (int ch = 0; ch < 3; ch++) begin
        if ($urandom_range(0, 1) || written_prefix(ch) == 0) begin
          if ($urandom_range(0, 5) == 0) begin
            load_table(ch, 64);
            items += 64;
          end else begin
            c[0] = 7'($urandom_range(1, 8));
            load_table(ch, c[0]);
            items += c[0];
          end
        end
      end
      for (int ch = 0; ch < 3; ch++) pick_count(ch, c[ch]);
      set_counts(c[0], c[1], c[2]);
      for (int q = 0; q < 24; q++) begin
        case ($urandom_range(0, 11))
          0: send_item(CMD_WRITE, 2'd3, 6'($urandom), $urandom, $urandom, $urandom);
          1: send_item(CMD_WRITE, 2'($urandom_range(0, 2)), 6'($urandom), $urandom,
                       $urandom, $urandom);
          default: send_item(CMD_EVAL, 2'($urandom), 6'($urandom), $urandom, $urandom,
                             pick_query());
        endcase
        items++;
      end
    end

    drain();
    if (errors == 0) begin
      $display("keyframe_curve_evaluator_top: match");
    end else begin
      $display("keyframe_curve_evaluator_top: mismatch");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("keyframe_curve_evaluator_top: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
design/kce_pkg.sv
design/kce_ram.sv
design/kce_div.sv
design/keyframe_curve_evaluator_top.sv
tb/sv/testbench.sv
